>>> design/nnt_pkg.sv
// Shared types, constants and tables for the numbered-notation tone block.
// Used by nnt_front, nnt_queue, nnt_back and numbered_notation_to_tone.
// Has no dependencies of its own.
package nnt_pkg;

  localparam int FREQ_FRAC_BITS   = 8;
  localparam int MAX_OCTAVE_SHIFT = 8;
  localparam int TABLE_FRAC       = 16;

  // Pitch index x = key + degree + semitones + XOffset stays within -1..297.
  localparam int XOffset   = 144;
  localparam int ShiftBias = FREQ_FRAC_BITS - TABLE_FRAC + (600 - XOffset) / 12 - 50;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int PaddrW = 4;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSharp = 8'h23;
  localparam logic [7:0] ChFlat  = 8'h62;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [1:0] {
    REG_KEY_SEMITONES = 2'd0,
    REG_KEY_VALID     = 2'd1,
    REG_NOTE_DURATION = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_DASH = 2'd1,
    CMD_NOTE = 2'd2,
    CMD_REST = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic signed [7:0] key_semitones;
    logic              key_valid;
    logic [31:0]       note_duration;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              flush;
    logic [3:0]        tone_idx;
    logic signed [6:0] shift;
    logic [4:0]        halvings;
  } cmd_t;

  function automatic logic [24:0] tone_q16(input logic [3:0] k);
    logic [24:0] t;
    case (k)
      4'd0:    t = 25'd17146184;
      4'd1:    t = 25'd18165749;
      4'd2:    t = 25'd19245940;
      4'd3:    t = 25'd20390364;
      4'd4:    t = 25'd21602838;
      4'd5:    t = 25'd22887409;
      4'd6:    t = 25'd24248366;
      4'd7:    t = 25'd25690248;
      4'd8:    t = 25'd27217870;
      4'd9:    t = 25'd28836329;
      4'd10:   t = 25'd30551026;
      4'd11:   t = 25'd32367685;
      default: t = 25'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [4:0] degree_semis(input logic [2:0] d);
    logic signed [4:0] s;
    case (d)
      3'd0:    s = -5'sd1;
      3'd1:    s = 5'sd0;
      3'd2:    s = 5'sd2;
      3'd3:    s = 5'sd4;
      3'd4:    s = 5'sd5;
      3'd5:    s = 5'sd7;
      3'd6:    s = 5'sd9;
      3'd7:    s = 5'sd11;
      default: s = 5'sd0;
    endcase
    return s;
  endfunction

endpackage

>>> design/numbered_notation_to_tone.sv
// Numbered-notation text to tone converter, top level.
// Holds the configuration registers and connects nnt_front, nnt_queue and
// nnt_back. Depends on nnt_pkg.
//
// Text enters one byte per beat on the input channel (character_i with
// end_of_text_i); tones leave on the result channel as frequency_o (Q24.8 Hz,
// zero for a rest), duration_o (Q16.16) and last_of_piece_o.
// The input channel takes one beat per cycle while the queue is not full. A
// beat that closes a dash, note or rest token, or ends the text, pushes a
// command into a four-entry queue; while the result channel is free the back
// end retires one command per cycle, and a result passes through the queue and
// then the result register. An end of text that closes a note while another
// is held is retired only after two results, the held tone first.
// A tone is held until the next note or rest token or the end of text closes.
// When the receiver stalls, the result register holds its beat, the back end
// stops and the queue fills; in_ready_o falls only when the queue is full.
// Reset clears the token state, the queue, the held tone and the result
// register, and sets key 0, key valid and a note duration of 1.0.
// Registers on the APB port: key_semitones at 0x0, key_valid at 0x4 and
// note_duration at 0x8; write them only while the block is idle.
module numbered_notation_to_tone (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 character_i,
  input  logic                       end_of_text_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [31:0]                frequency_o,
  output logic [31:0]                duration_o,
  output logic                       last_of_piece_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nnt_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  nnt_pkg::cfg_t     cfg_q;
  nnt_pkg::reg_idx_e reg_idx;
  logic              cfg_write;
  logic              push;
  nnt_pkg::cmd_t     push_cmd;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  nnt_pkg::cmd_t     head;

  assign pready    = 1'b1;
  assign reg_idx   = nnt_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_semitones <= '0;
      cfg_q.key_valid     <= 1'b1;
      cfg_q.note_duration <= 32'd65536;
    end else if (cfg_write) begin
      case (reg_idx)
        nnt_pkg::REG_KEY_SEMITONES: cfg_q.key_semitones <= pwdata[7:0];
        nnt_pkg::REG_KEY_VALID:     cfg_q.key_valid     <= pwdata[0];
        nnt_pkg::REG_NOTE_DURATION: cfg_q.note_duration <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nnt_pkg::REG_KEY_SEMITONES: prdata = {24'd0, cfg_q.key_semitones};
      nnt_pkg::REG_KEY_VALID:     prdata = {31'd0, cfg_q.key_valid};
      nnt_pkg::REG_NOTE_DURATION: prdata = cfg_q.note_duration;
      default:                    prdata = '0;
    endcase
  end

  assign in_ready_o = !q_full;

  nnt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .character_i   (character_i),
    .end_of_text_i (end_of_text_i),
    .cfg_i         (cfg_q),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  nnt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  nnt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frequency_o     (frequency_o),
    .duration_o      (duration_o),
    .last_of_piece_o (last_of_piece_o)
  );

endmodule

>>> design/nnt_front.sv
// Tokenizer front end: accepts text beats, tracks the open token and
// pushes one command per closed dash, note or rest token or per end of text
// into the queue. Depends on nnt_pkg.
module nnt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [7:0]    character_i,
  input  logic          end_of_text_i,
  input  nnt_pkg::cfg_t cfg_i,
  output logic          push_o,
  output nnt_pkg::cmd_t cmd_o
);

  logic              in_token_q, in_token_d;
  logic [1:0]        len_q, len_d;
  logic [7:0]        first_q, first_d;
  logic signed [4:0] oct_q, oct_d;
  logic signed [4:0] semi_q, semi_d;
  logic [4:0]        halv_q, halv_d;

  logic              accept;
  logic              is_space;
  logic              is_dash;
  logic              is_digit;
  nnt_pkg::cmd_kind_e kind;
  logic signed [9:0] x_s;
  logic [8:0]        x;
  logic [16:0]       prod;
  logic [4:0]        qx;
  logic [8:0]        rem;
  logic signed [6:0] shift;

  assign accept   = in_valid_i && in_ready_i;
  assign is_space = (character_i == nnt_pkg::ChSpace) ||
                    ((character_i >= nnt_pkg::ChTab) && (character_i <= nnt_pkg::ChCr));
  assign is_dash  = in_token_q && (len_q == 2'd1) && (first_q == nnt_pkg::ChMinus);
  assign is_digit = in_token_q && (first_q >= nnt_pkg::ChZero) &&
                    (first_q <= nnt_pkg::ChSeven);

  always_comb begin
    if (is_dash) begin
      kind = nnt_pkg::CMD_DASH;
    end else if (is_digit && (first_q == nnt_pkg::ChZero)) begin
      kind = nnt_pkg::CMD_REST;
    end else if (is_digit) begin
      kind = nnt_pkg::CMD_NOTE;
    end else begin
      kind = nnt_pkg::CMD_NONE;
    end
  end

  // The multiply by 171 and shift by 11 is an exact floor of x / 12 for x below 300.
  always_comb begin
    x_s   = 10'(cfg_i.key_semitones) + 10'(nnt_pkg::degree_semis(first_q[2:0])) +
            10'(semi_q) + 10'(nnt_pkg::XOffset);
    x     = x_s[8:0];
    prod  = 17'(x) * 17'd171;
    qx    = prod[15:11];
    rem   = x - 9'(qx) * 9'd12;
    shift = 7'(qx) + 7'(oct_q) + 7'(nnt_pkg::ShiftBias);
  end

  always_comb begin
    cmd_o.kind     = kind;
    cmd_o.flush    = end_of_text_i;
    cmd_o.tone_idx = rem[3:0];
    cmd_o.shift    = shift;
    cmd_o.halvings = halv_q;
  end

  always_comb begin
    in_token_d = in_token_q;
    len_d      = len_q;
    first_d    = first_q;
    oct_d      = oct_q;
    semi_d     = semi_q;
    halv_d     = halv_q;
    push_o     = 1'b0;
    if (accept) begin
      if (end_of_text_i || is_space) begin
        push_o     = end_of_text_i || (kind != nnt_pkg::CMD_NONE);
        in_token_d = 1'b0;
        len_d      = '0;
        first_d    = '0;
        oct_d      = '0;
        semi_d     = '0;
        halv_d     = '0;
      end else if (!in_token_q) begin
        in_token_d = 1'b1;
        len_d      = 2'd1;
        first_d    = character_i;
        oct_d      = '0;
        semi_d     = '0;
        halv_d     = '0;
      end else begin
        if (len_q != 2'd3) begin
          len_d = len_q + 2'd1;
        end
        case (character_i)
          nnt_pkg::ChPlus: begin
            if (oct_q < 5'(nnt_pkg::MAX_OCTAVE_SHIFT)) oct_d = oct_q + 5'sd1;
          end
          nnt_pkg::ChMinus: begin
            if (oct_q > -5'(nnt_pkg::MAX_OCTAVE_SHIFT)) oct_d = oct_q - 5'sd1;
          end
          nnt_pkg::ChSharp: begin
            if (semi_q < 5'sd15) semi_d = semi_q + 5'sd1;
          end
          nnt_pkg::ChFlat: begin
            if (semi_q > -5'sd16) semi_d = semi_q - 5'sd1;
          end
          nnt_pkg::ChUnder: begin
            if (halv_q != 5'd31) halv_d = halv_q + 5'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q <= 1'b0;
      len_q      <= '0;
      first_q    <= '0;
      oct_q      <= '0;
      semi_q     <= '0;
      halv_q     <= '0;
    end else begin
      in_token_q <= in_token_d;
      len_q      <= len_d;
      first_q    <= first_d;
      oct_q      <= oct_d;
      semi_q     <= semi_d;
      halv_q     <= halv_d;
    end
  end

endmodule

>>> design/nnt_queue.sv
// Small command queue between the tokenizer and the tone back end.
// Depends on nnt_pkg for the entry type and depth.
module nnt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nnt_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output nnt_pkg::cmd_t head_o
);

  nnt_pkg::cmd_t                   mem_q [nnt_pkg::QDepth];
  logic [nnt_pkg::QPtrW-1:0]       wptr_q, wptr_d;
  logic [nnt_pkg::QPtrW-1:0]       rptr_q, rptr_d;
  logic [nnt_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o       = (cnt_q == nnt_pkg::QCntW'(nnt_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + nnt_pkg::QCntW'(do_push) - nnt_pkg::QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> design/nnt_back.sv
// Tone back end: turns queued commands into held tones, extends them on
// dashes and drives the registered result channel. Depends on nnt_pkg.
module nnt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nnt_pkg::cfg_t cfg_i,
  input  logic          head_valid_i,
  input  nnt_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   frequency_o,
  output logic [31:0]   duration_o,
  output logic          last_of_piece_o
);

  logic        held_valid_q, held_valid_d;
  logic [31:0] held_freq_q, held_freq_d;
  logic [31:0] held_dur_q, held_dur_d;
  logic        phase_q, phase_d;
  logic        out_valid_q;
  logic [31:0] out_freq_q;
  logic [31:0] out_dur_q;
  logic        out_last_q;

  logic        out_free;
  logic        emit;
  logic [31:0] emit_freq;
  logic [31:0] emit_dur;
  logic        emit_last;
  logic        is_tone;
  logic [63:0] tone_w;
  logic [63:0] shifted;
  logic [6:0]  neg_shift;
  logic [31:0] new_freq;
  logic [31:0] new_dur;
  logic [32:0] dur_sum;
  logic [31:0] dur_eff;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_tone  = (head_i.kind == nnt_pkg::CMD_NOTE) || (head_i.kind == nnt_pkg::CMD_REST);

  always_comb begin
    tone_w    = 64'(nnt_pkg::tone_q16(head_i.tone_idx));
    neg_shift = 7'(-head_i.shift);
    shifted   = '0;
    new_freq  = '0;
    if (head_i.kind == nnt_pkg::CMD_NOTE) begin
      if (head_i.shift >= 7'sd0) begin
        shifted = tone_w << head_i.shift[5:0];
        if ((head_i.shift > 7'sd39) || (shifted[63:32] != '0)) begin
          new_freq = '1;
        end else begin
          new_freq = shifted[31:0];
        end
      end else if (neg_shift <= 7'd26) begin
        shifted  = (tone_w + (64'd1 << (neg_shift - 7'd1))) >> neg_shift;
        new_freq = shifted[31:0];
      end
    end
    new_dur = cfg_i.note_duration >> head_i.halvings;
    dur_sum = 33'(held_dur_q) + 33'(cfg_i.note_duration);
    if ((head_i.kind == nnt_pkg::CMD_DASH) && held_valid_q) begin
      dur_eff = dur_sum[32] ? '1 : dur_sum[31:0];
    end else begin
      dur_eff = held_dur_q;
    end
  end

  always_comb begin
    held_valid_d = held_valid_q;
    held_freq_d  = held_freq_q;
    held_dur_d   = held_dur_q;
    phase_d      = phase_q;
    pop_o        = 1'b0;
    emit         = 1'b0;
    emit_freq    = held_freq_q;
    emit_dur     = held_dur_q;
    emit_last    = 1'b0;
    if (head_valid_i) begin
      if (phase_q) begin
        if (out_free) begin
          emit         = 1'b1;
          emit_last    = 1'b1;
          held_valid_d = 1'b0;
          phase_d      = 1'b0;
          pop_o        = 1'b1;
        end
      end else if (!cfg_i.key_valid) begin
        pop_o = 1'b1;
        if (is_tone || head_i.flush) begin
          held_valid_d = 1'b0;
        end
      end else if (is_tone) begin
        if (held_valid_q) begin
          if (out_free) begin
            emit        = 1'b1;
            held_freq_d = new_freq;
            held_dur_d  = new_dur;
            if (head_i.flush) begin
              phase_d = 1'b1;
            end else begin
              pop_o = 1'b1;
            end
          end
        end else if (head_i.flush) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_freq = new_freq;
            emit_dur  = new_dur;
            emit_last = 1'b1;
            pop_o     = 1'b1;
          end
        end else begin
          held_valid_d = 1'b1;
          held_freq_d  = new_freq;
          held_dur_d   = new_dur;
          pop_o        = 1'b1;
        end
      end else if (head_i.flush) begin
        if (held_valid_q) begin
          if (out_free) begin
            emit         = 1'b1;
            emit_dur     = dur_eff;
            emit_last    = 1'b1;
            held_valid_d = 1'b0;
            pop_o        = 1'b1;
          end
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        held_dur_d = dur_eff;
        pop_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_freq_q <= held_freq_d;
    held_dur_q  <= held_dur_d;
    if (emit) begin
      out_freq_q <= emit_freq;
      out_dur_q  <= emit_dur;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      phase_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      phase_q      <= phase_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frequency_o     = out_freq_q;
  assign duration_o      = out_dur_q;
  assign last_of_piece_o = out_last_q;

endmodule

>>> design/nnt_checker.sv
// Port-level checks for numbered_notation_to_tone, bound to the top level.
// Depends on the top level's ports and on nnt_pkg for the register indexes.
module nnt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [31:0]                frequency_o,
  input logic [31:0]                duration_o,
  input logic                       last_of_piece_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [nnt_pkg::PaddrW-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(frequency_o) && $stable(duration_o) && $stable(last_of_piece_o))
    else $error("Result payload changed while stalled.");

  a_dur_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == {nnt_pkg::REG_NOTE_DURATION, 2'b00}) ##1
    (psel && !pwrite && paddr == {nnt_pkg::REG_NOTE_DURATION, 2'b00}) |->
      prdata == $past(pwdata))
    else $error("Note duration register did not read back.");

  a_key_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == {nnt_pkg::REG_KEY_SEMITONES, 2'b00}) ##1
    (psel && !pwrite && paddr == {nnt_pkg::REG_KEY_SEMITONES, 2'b00}) |->
      prdata[7:0] == $past(pwdata[7:0]))
    else $error("Key register did not read back.");

endmodule

bind numbered_notation_to_tone nnt_checker u_nnt_checker (.*);
